// ===== design/slc_pkg.sv =====
// Shared constants for the sector light colour core.
`timescale 1ns / 1ps
package slc_pkg;

  // Configuration register indexes.
  localparam logic CFG_LIGHT_MODE = 1'b0;
  localparam logic CFG_AMBIENT    = 1'b1;

  // Register widths and reset values.
  localparam int unsigned ModeW = 5;
  localparam int unsigned ByteW = 8;
  localparam logic [ModeW-1:0] LIGHT_MODE_RST = 5'd3;
  localparam logic [ByteW-1:0] AMBIENT_RST    = 8'd20;

  // Lighting modes with special meaning.
  localparam logic [ModeW-1:0] MODE_SOFTWARE = 5'd8;
  localparam logic [ModeW-1:0] MODE_CHANNEL  = 5'd16;

  // Dark ramp: levels below this are darkened.
  localparam logic [ByteW-1:0] RAMP_LIMIT = 8'd192;

  // The ramp numerator is rebased to 39*level - 38 (always positive for a
  // non-zero level); dividing it by 20 and subtracting 180 gives the
  // floored ramp value.
  localparam logic [13:0] RAMP_MUL    = 14'd39;
  localparam logic [13:0] RAMP_SUB    = 14'd38;
  localparam logic [12:0] DIV20_RECIP = 13'd6554;
  localparam int unsigned DIV20_SHIFT = 17;
  localparam logic signed [9:0] RAMP_BIAS = 10'sd180;

  // Division by 255 of a value below 65536 as a reciprocal multiply.
  localparam logic [31:0] DIV255_RECIP = 32'd32897;
  localparam int unsigned DIV255_SHIFT = 23;

  // Item types.
  typedef logic [2:0][ByteW-1:0] rgb_t;
  typedef logic [2:0][15:0]      rgb_wide_t;

endpackage

// ===== design/sector_light_color_core.sv =====
// Sector light level and colour pipeline: top level.
`timescale 1ns / 1ps
// The core turns one lighting request per cycle, while the sink keeps up, into
// an effective light level and an RGB light colour. Every request passes four
// register stages: the first forms the dark ramp numerator, the second divides
// it and applies the ambient floor, relative light and clamp, the third forms
// the colour products, and the fourth divides them by 255 or passes the colour
// through, adds the per-channel relative light in mode 16, and holds the result
// in the output register. A new request can be taken in every cycle while the
// sink is ready. Each stage advances on its own, so a stalled sink only holds
// back stages that are full, and bubbles close up. Configuration writes are
// taken at any time but should only be made while no request is in flight.
module sector_light_color_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: light_level[7:0], relative_light[16:8], light_red[24:17],
  // light_green[32:25], light_blue[40:33], blend_factor[48:41], zero[55:49]
  input  logic [55:0] s_axis_tdata,
  // tuser: is_weapon[0], force_color[1]
  input  logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: level_out[7:0], red[15:8], green[23:16], blue[31:24]
  output logic [31:0] m_axis_tdata
);
  import slc_pkg::*;

  // Configuration registers.
  logic [ModeW-1:0] light_mode_q;
  logic [ByteW-1:0] ambient_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_mode_q <= LIGHT_MODE_RST;
      ambient_q    <= AMBIENT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LIGHT_MODE: light_mode_q <= cfg_data_i[ModeW-1:0];
        CFG_AMBIENT:    ambient_q    <= cfg_data_i;
        default:        ambient_q    <= ambient_q;
      endcase
    end
  end

  logic soft_mode;
  logic chan_mode;
  assign chan_mode = (light_mode_q == MODE_CHANNEL);
  assign soft_mode = (light_mode_q == MODE_SOFTWARE) || chan_mode;

  // Stage valid bits and the ready chain back from the sink.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy2, rdy3, rdy4;
  assign rdy4          = !v4_q || m_axis_tready;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign s_axis_tready = !v1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (s_axis_tready) v1_q <= s_axis_tvalid;
      if (rdy2)          v2_q <= v1_q;
      if (rdy3)          v3_q <= v2_q;
      if (rdy4)          v4_q <= v3_q;
    end
  end

  // Stage 1: unpack the request and form the rebased ramp numerator.
  logic [7:0]        in_lvl;
  logic [13:0]       ramp_num;
  logic [7:0]        s1_lvl_q;
  logic signed [8:0] s1_rel_q;
  logic              s1_ramp_q;
  logic [12:0]       s1_num_q;
  rgb_t              s1_col_q;
  logic [7:0]        s1_bf_q;
  logic              s1_force_q;

  assign in_lvl   = s_axis_tdata[7:0];
  assign ramp_num = {6'd0, in_lvl} * RAMP_MUL - RAMP_SUB;

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_lvl_q    <= in_lvl;
      s1_rel_q    <= $signed(s_axis_tdata[16:8]);
      s1_ramp_q   <= light_mode_q[1] && (in_lvl < RAMP_LIMIT) && !s_axis_tuser[0];
      s1_num_q    <= ramp_num[12:0];
      s1_col_q[0] <= s_axis_tdata[24:17];
      s1_col_q[1] <= s_axis_tdata[32:25];
      s1_col_q[2] <= s_axis_tdata[40:33];
      s1_bf_q     <= s_axis_tdata[48:41];
      s1_force_q  <= s_axis_tuser[1];
    end
  end

  // Stage 2: finish the ramp, apply the ambient floor and relative light.
  logic [25:0]        div20_prod;
  logic [8:0]         ramp_q20;
  logic signed [9:0]  light;
  logic [7:0]         amb;
  logic               lift;
  logic signed [8:0]  rel_adj;
  logic signed [9:0]  base;
  logic signed [10:0] lvl_sum;
  logic [7:0]         level_d;

  assign div20_prod = s1_num_q * DIV20_RECIP;
  assign ramp_q20   = div20_prod[DIV20_SHIFT +: 9];
  assign amb        = (ambient_q == 8'd0) ? 8'd1 : ambient_q;

  always_comb begin
    if (s1_ramp_q) begin
      light = $signed({1'b0, ramp_q20}) - RAMP_BIAS;
    end else begin
      light = $signed({2'b00, s1_lvl_q});
    end
    lift    = (light < $signed({2'b00, amb})) && !soft_mode;
    rel_adj = chan_mode ? 9'sd0 : s1_rel_q;
    // Negative relative light is halved, rounding down, when lifted.
    if (lift && rel_adj[8]) begin
      rel_adj = rel_adj >>> 1;
    end
    base    = lift ? $signed({2'b00, amb}) : light;
    lvl_sum = 11'(base) + 11'(rel_adj);
    if (s1_lvl_q == 8'd0) begin
      level_d = 8'd0;
    end else if (lvl_sum < 0) begin
      level_d = 8'd0;
    end else if (lvl_sum > 11'sd255) begin
      level_d = 8'd255;
    end else begin
      level_d = lvl_sum[7:0];
    end
  end

  logic [7:0]        s2_level_q;
  logic signed [8:0] s2_rel_q;
  rgb_t              s2_col_q;
  logic [7:0]        s2_bf_q;
  logic              s2_pass_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_level_q <= level_d;
      s2_rel_q   <= s1_rel_q;
      s2_col_q   <= s1_col_q;
      s2_bf_q    <= s1_bf_q;
      s2_pass_q  <= soft_mode && !s1_force_q;
    end
  end

  // Stage 3: scale or blend each channel with the level.
  rgb_wide_t mix_d;
  logic [7:0] inv_bf;
  assign inv_bf = 8'd255 - s2_bf_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (s2_bf_q == 8'd0) begin
        mix_d[c] = {8'd0, s2_col_q[c]} * {8'd0, s2_level_q};
      end else begin
        mix_d[c] = {8'd0, s2_level_q} * {8'd0, inv_bf}
                 + {8'd0, s2_col_q[c]} * {8'd0, s2_bf_q};
      end
    end
  end

  rgb_wide_t         s3_mix_q;
  rgb_t              s3_col_q;
  logic [7:0]        s3_level_q;
  logic signed [8:0] s3_rel_q;
  logic              s3_pass_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_mix_q   <= mix_d;
      s3_col_q   <= s2_col_q;
      s3_level_q <= s2_level_q;
      s3_rel_q   <= s2_rel_q;
      s3_pass_q  <= s2_pass_q;
    end
  end

  // Stage 4: divide by 255 or pass the colour through, then add relative light per channel in mode 16.
  logic [2:0][31:0]        div255_prod;
  rgb_t                    chan;
  logic [2:0][9:0]         chan_sum;
  rgb_t                    rgb_d;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      div255_prod[c] = {16'd0, s3_mix_q[c]} * DIV255_RECIP;
      chan[c]        = s3_pass_q ? s3_col_q[c] : div255_prod[c][DIV255_SHIFT +: 8];
      chan_sum[c]    = $unsigned($signed({2'b00, chan[c]}) + 10'(s3_rel_q));
      if (!chan_mode) begin
        rgb_d[c] = chan[c];
      end else if (chan_sum[c][9]) begin
        rgb_d[c] = 8'd0;
      end else if (chan_sum[c][8]) begin
        rgb_d[c] = 8'd255;
      end else begin
        rgb_d[c] = chan_sum[c][7:0];
      end
    end
  end

  logic [7:0] out_level_q;
  rgb_t       out_rgb_q;

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      out_level_q <= s3_level_q;
      out_rgb_q   <= rgb_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {out_rgb_q[2], out_rgb_q[1], out_rgb_q[0], out_level_q};

  // A ready sink never holds back the request side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("request side stalled while sink is ready");

  // An accepted request always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted request lost at stage 1");

  // A full third stage moves into the output register when it has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4) |=> m_axis_tvalid)
    else $error("stage 3 result lost on its way to the output");

  // A full stage 2 only stalls when stage 3 is full as well.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !rdy3) |-> (v3_q && v4_q))
    else $error("stage 2 stalled with room downstream");

endmodule

// ===== tb/sector_light_color_core_test.sv =====
// Self-checking testbench for the sector light colour core.
`timescale 1ns / 1ps
module sector_light_color_core_test;
  import slc_pkg::*;

  // One lighting request as it is driven on the request stream.
  typedef struct packed {
    logic [7:0] level;
    logic [8:0] rel;
    logic       weapon;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] blend;
    logic       force_color;
  } light_req_t;

  // One result, laid out as on the result stream (level in the lowest byte).
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] level;
  } light_result_t;

  // A row of the directed table: register setting, request and, where it is
  // obvious, the result typed in by hand.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ByteW-1:0] ambient;
    light_req_t       req;
    logic             typed;
    light_result_t    want;
  } stim_row_t;

  localparam int DIR_ROWS     = 22;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int SETTLE_TICKS = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_LIGHT_MODE;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  sector_light_color_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a 12 ns period.
  always #6 clk_i = ~clk_i;

  light_result_t    pending_colours[$];
  logic [ModeW-1:0] cur_mode = LIGHT_MODE_RST;
  logic [ByteW-1:0] cur_ambient = AMBIENT_RST;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  logic             hold_rx = 1'b0;
  int               colour_errors = 0;
  int               results_seen = 0;
  int               requests_sent = 0;
  int               settings_used = 1;
  int unsigned      quiet_cycles = 0;
  light_result_t    rx_got;
  light_result_t    rx_want;
  stim_row_t        stim_table [DIR_ROWS];

  function automatic int clamp_byte(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // Expected level and colour for one request under the given registers.
  function automatic light_result_t predict_light(input logic [ModeW-1:0] mode,
                                                  input logic [ByteW-1:0] ambient,
                                                  input light_req_t rq);
    int            lvl;
    int            rel;
    int            rel_lvl;
    int            light;
    int            floor_lvl;
    int            num;
    int            lev;
    int            chan;
    int            col [3];
    int            res [3];
    bit            sw_mode;
    light_result_t out;
    lvl     = rq.level;
    rel     = $signed(rq.rel);
    sw_mode = (mode == MODE_SOFTWARE) || (mode == MODE_CHANNEL);
    rel_lvl = (mode == MODE_CHANNEL) ? 0 : rel;
    col[0]  = rq.red;
    col[1]  = rq.green;
    col[2]  = rq.blue;
    // Level: dark ramp, ambient floor with halved negative offset, clamp.
    if (lvl == 0) begin
      lev = 0;
    end else begin
      if (mode[1] && lvl < RAMP_LIMIT && !rq.weapon) begin
        num   = 3850 - 39 * (192 - lvl);
        light = (num >= 0) ? num / 20 : -((-num + 19) / 20);
      end else begin
        light = lvl;
      end
      floor_lvl = (ambient == 0) ? 1 : ambient;
      if (light < floor_lvl && !sw_mode) begin
        light = floor_lvl;
        if (rel_lvl < 0) rel_lvl = -((-rel_lvl + 1) / 2);
      end
      lev = clamp_byte(light + rel_lvl);
    end
    // Colour: passthrough, multiply or blend, then the per-channel offset.
    for (int i = 0; i < 3; i++) begin
      if (sw_mode && !rq.force_color) begin
        chan = col[i];
      end else if (rq.blend == 0) begin
        chan = col[i] * lev / 255;
      end else begin
        chan = (lev * (255 - rq.blend) + col[i] * rq.blend) / 255;
      end
      chan = chan & 255;
      if (mode == MODE_CHANNEL) chan = clamp_byte(chan + rel);
      res[i] = chan;
    end
    out.level = lev[7:0];
    out.red   = res[0][7:0];
    out.green = res[1][7:0];
    out.blue  = res[2][7:0];
    return out;
  endfunction

  function automatic stim_row_t mk_row(input int mode, input int ambient, input int lvl,
                                       input int rel, input int weapon, input int red,
                                       input int green, input int blue, input int blend,
                                       input int force_col, input int typed,
                                       input int want);
    stim_row_t row;
    row.mode            = mode[ModeW-1:0];
    row.ambient         = ambient[7:0];
    row.req.level       = lvl[7:0];
    row.req.rel         = rel[8:0];
    row.req.weapon      = weapon[0];
    row.req.red         = red[7:0];
    row.req.green       = green[7:0];
    row.req.blue        = blue[7:0];
    row.req.blend       = blend[7:0];
    row.req.force_color = force_col[0];
    row.typed           = typed[0];
    row.want            = want;
    return row;
  endfunction

  // Random request, weighted toward the edges of each field.
  function automatic light_req_t random_request();
    light_req_t rq;
    case ($urandom_range(7))
      0:       rq.level = 8'd0;
      1:       rq.level = 8'd255;
      2:       rq.level = 8'($urandom_range(191, 185));
      3:       rq.level = 8'($urandom_range(12, 1));
      default: rq.level = 8'($urandom_range(255));
    endcase
    case ($urandom_range(7))
      0:       rq.rel = 9'(-255);
      1:       rq.rel = 9'd255;
      2:       rq.rel = 9'd0;
      3:       rq.rel = 9'(int'($urandom_range(16)) - 8);
      default: rq.rel = 9'(int'($urandom_range(510)) - 255);
    endcase
    rq.weapon      = 1'($urandom_range(1));
    rq.red         = ($urandom_range(5) == 0) ? 8'd255 : 8'($urandom_range(255));
    rq.green       = ($urandom_range(5) == 0) ? 8'd255 : 8'($urandom_range(255));
    rq.blue        = ($urandom_range(5) == 0) ? 8'd0 : 8'($urandom_range(255));
    case ($urandom_range(7))
      0, 1:    rq.blend = 8'd0;
      2:       rq.blend = 8'd255;
      default: rq.blend = 8'($urandom_range(255));
    endcase
    rq.force_color = 1'($urandom_range(1));
    return rq;
  endfunction

  // Offers one request, with random idle cycles first, and records its expected result.
  task automatic send_request(input light_req_t rq, input light_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, rq.blend, rq.blue, rq.green, rq.red, rq.rel, rq.level};
    s_axis_tuser  <= {rq.force_color, rq.weapon};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_colours.push_back(want);
    requests_sent++;
  endtask

  // Stops offering and waits until every result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // Writes both registers on consecutive edges.
  task automatic apply_setting(input logic [ModeW-1:0] mode, input logic [ByteW-1:0] ambient);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_LIGHT_MODE;
    cfg_data_i  <= {3'd0, mode};
    @(posedge clk_i);
    cfg_index_i <= CFG_AMBIENT;
    cfg_data_i  <= ambient;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_mode    = mode;
    cur_ambient = ambient;
    settings_used++;
  endtask

  task automatic send_phase(input int count);
    light_req_t rq;
    for (int i = 0; i < count; i++) begin
      rq = random_request();
      send_request(rq, predict_light(cur_mode, cur_ambient, rq));
    end
  endtask

  // Result side: random back-pressure and comparison with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        rx_got = m_axis_tdata;
        if (pending_colours.size() == 0) begin
          colour_errors++;
          if (colour_errors <= 10)
            $display("Result %h arrived with nothing expected", rx_got);
        end else begin
          rx_want = pending_colours.pop_front();
          results_seen++;
          if (rx_got.level != rx_want.level || rx_got.red != rx_want.red ||
              rx_got.green != rx_want.green || rx_got.blue != rx_want.blue) begin
            colour_errors++;
            if (colour_errors <= 10)
              $display("Result %0d: expected level %0d rgb %0d %0d %0d, got level %0d rgb %0d %0d %0d",
                       results_seen, rx_want.level, rx_want.red, rx_want.green, rx_want.blue,
                       rx_got.level, rx_got.red, rx_got.green, rx_got.blue);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither stream moves.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("FAIL sector_light_color_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, then random phases over several settings.
  initial begin
    int phase_mode [PHASES];
    int phase_amb  [PHASES];
    light_result_t want;
    phase_mode = '{3, 0, 2, MODE_SOFTWARE, MODE_CHANNEL, 31, 10, 18, 1};
    phase_amb  = '{20, 1, 255, 1, 255, 0, 128, 7, 200};
    stim_table = '{
      // Reset registers: dark sector, full bright, deep ramp, ambient floor.
      mk_row(3, 20, 0, 0, 0, 255, 255, 255, 0, 0, 1, 'h0000_0000),
      mk_row(3, 20, 255, 0, 0, 255, 255, 255, 0, 0, 1, 'hFFFF_FFFF),
      mk_row(3, 20, 1, -255, 0, 128, 64, 32, 0, 0, 0, 0),
      mk_row(3, 20, 1, -1, 0, 255, 255, 255, 0, 0, 0, 0),
      mk_row(3, 20, 191, 255, 0, 255, 255, 255, 255, 0, 0, 0),
      mk_row(3, 20, 192, 0, 0, 10, 20, 30, 0, 1, 0, 0),
      mk_row(3, 20, 100, 10, 1, 90, 180, 255, 0, 0, 0, 0),
      mk_row(3, 20, 150, -100, 0, 200, 100, 50, 128, 1, 0, 0),
      // Ambient register at zero behaves as one.
      mk_row(0, 0, 5, -3, 0, 255, 0, 255, 0, 0, 0, 0),
      mk_row(0, 0, 1, -255, 1, 255, 255, 255, 9, 1, 0, 0),
      // Highest ambient.
      mk_row(2, 255, 255, -255, 0, 17, 34, 51, 0, 0, 0, 0),
      mk_row(2, 255, 10, 255, 0, 0, 128, 255, 1, 0, 0, 0),
      // Software passthrough, with and without forced colour.
      mk_row(MODE_SOFTWARE, 20, 100, 0, 0, 12, 34, 56, 0, 0, 1, 'h3822_0C64),
      mk_row(MODE_SOFTWARE, 20, 1, -255, 0, 255, 255, 255, 0, 1, 0, 0),
      mk_row(MODE_SOFTWARE, 20, 200, 50, 1, 1, 2, 3, 77, 0, 0, 0),
      // Per-channel relative light.
      mk_row(MODE_CHANNEL, 20, 255, -255, 0, 255, 255, 255, 0, 0, 1, 'h0000_00FF),
      mk_row(MODE_CHANNEL, 20, 0, 255, 0, 0, 0, 0, 0, 0, 1, 'hFFFF_FF00),
      mk_row(MODE_CHANNEL, 20, 120, 30, 0, 200, 10, 255, 0, 1, 0, 0),
      mk_row(MODE_CHANNEL, 20, 60, -40, 0, 5, 250, 128, 200, 1, 0, 0),
      // Undefined mode values still use bit 1 for the ramp.
      mk_row(31, 100, 50, -77, 0, 255, 255, 255, 0, 0, 0, 0),
      mk_row(31, 100, 191, 0, 1, 40, 80, 160, 255, 1, 0, 0),
      mk_row(10, 20, 3, 0, 0, 255, 128, 0, 0, 0, 0, 0)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, first rows under the reset values of the registers.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (stim_table[r].mode != cur_mode || stim_table[r].ambient != cur_ambient) begin
        drain();
        apply_setting(stim_table[r].mode, stim_table[r].ambient);
      end
      want = stim_table[r].typed ? stim_table[r].want
                                 : predict_light(cur_mode, cur_ambient, stim_table[r].req);
      send_request(stim_table[r].req, want);
    end

    // Random phases, cycling through the idling profiles.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      apply_setting(phase_mode[p][ModeW-1:0], phase_amb[p][ByteW-1:0]);
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 48; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      if (p == 4) begin
        // The sink holds off for a long stretch while requests keep coming.
        fork
          begin
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            hold_rx <= 1'b0;
          end
          send_phase(PHASE_ITEMS);
        join
      end else begin
        send_phase(PHASE_ITEMS);
      end
    end
    drain();

    $display("Sent %0d lighting requests under %0d register settings and four idling profiles,",
             requests_sent, settings_used);
    $display("including a long sink hold-off; %0d results checked, %0d mismatches.",
             results_seen, colour_errors);
    if (colour_errors == 0 && pending_colours.size() == 0) begin
      $display("PASS sector_light_color_core");
    end else begin
      $display("FAIL sector_light_color_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/slc_pkg.sv
design/sector_light_color_core.sv
tb/sector_light_color_core_test.sv
